>>> sv/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared constants and types for the page translation core.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

    localparam int TLB_ENTRIES_DEF = 16;
    localparam int PAGE_COUNT_DEF  = 256;
    localparam int OFFSET_BITS_DEF = 8;

    localparam int VA_W  = 16;
    localparam int PA_W  = 16;
    localparam int CNT_W = 32;

    // stream payload widths
    localparam int IN_TDATA_W  = VA_W;
    localparam int OUT_TDATA_W = PA_W + 3 * CNT_W;
    localparam int OUT_TUSER_W = 2;

    // tuser bit positions on the result stream
    localparam int TUSER_HIT   = 0;
    localparam int TUSER_FAULT = 1;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

endpackage

>>> sv/tlbpt_tlb.sv
// ----------------------------------------------------------------------------
// tlbpt_tlb
// Fully associative translation buffer with round-robin (fifo) refill.
// ----------------------------------------------------------------------------
module tlbpt_tlb
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
    parameter int PAGE_W      = 8,
    parameter int FRAME_W     = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [PAGE_W-1:0]  lookup_page,
    output logic               hit,
    output logic [FRAME_W-1:0] hit_frame,
    input  logic               fill_en,
    input  logic [PAGE_W-1:0]  fill_page,
    input  logic [FRAME_W-1:0] fill_frame
);

    localparam int IDX_W = $clog2(TLB_ENTRIES);

    logic [PAGE_W-1:0]  tlb_page_reg  [TLB_ENTRIES];
    logic [FRAME_W-1:0] tlb_frame_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] tlb_valid_reg;
    logic [IDX_W-1:0]   fifo_ptr_reg;
    logic [IDX_W-1:0]   fifo_ptr_next;
    logic [TLB_ENTRIES-1:0] match_vec;

    always_comb
    begin
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            match_vec[i] = tlb_valid_reg[i] && (tlb_page_reg[i] == lookup_page);
        end
    end

    // lowest matching slot wins
    always_comb
    begin
        hit_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit_frame = tlb_frame_reg[i];
            end
        end
        hit = |match_vec;
    end

    assign fifo_ptr_next = (fifo_ptr_reg == IDX_W'(TLB_ENTRIES - 1)) ? '0
                         : fifo_ptr_reg + IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlb_valid_reg <= '0;
            fifo_ptr_reg  <= '0;
        end
        else if (fill_en)
        begin
            tlb_valid_reg[fifo_ptr_reg] <= 1'b1;
            fifo_ptr_reg                <= fifo_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill_en)
        begin
            tlb_page_reg[fifo_ptr_reg]  <= fill_page;
            tlb_frame_reg[fifo_ptr_reg] <= fill_frame;
        end
    end

`ifndef SYNTHESIS
    // entries are only filled on a miss, so a page never sits in two slots
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("tlb holds the same page in more than one slot");
`endif

endmodule

>>> sv/tlbpt_page_table.sv
// ----------------------------------------------------------------------------
// tlbpt_page_table
// Page table memory: resident flag and frame per page, registered read,
// cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module tlbpt_page_table
    import tlbpt_pkg::*;
#(
    parameter int PAGE_COUNT = PAGE_COUNT_DEF,
    parameter int FRAME_W    = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    output logic                          ready,
    input  logic                          rd_en,
    input  logic [$clog2(PAGE_COUNT)-1:0] rd_page,
    output logic                          rd_resident,
    output logic [FRAME_W-1:0]            rd_frame,
    input  logic                          wr_en,
    input  logic [$clog2(PAGE_COUNT)-1:0] wr_page,
    input  logic [FRAME_W-1:0]            wr_frame
);

    localparam int PAGE_W  = $clog2(PAGE_COUNT);
    localparam int ENTRY_W = FRAME_W + 1;

    logic [ENTRY_W-1:0] mem [PAGE_COUNT];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               clr_active_reg;
    logic [PAGE_W-1:0]  clr_addr_reg;
    logic               mem_we;
    logic [PAGE_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;

    // sweep writes non-resident entries while it runs
    always_comb
    begin
        mem_we    = clr_active_reg || wr_en;
        mem_waddr = clr_active_reg ? clr_addr_reg : wr_page;
        mem_wdata = clr_active_reg ? '0 : {1'b1, wr_frame};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + PAGE_W'(1);
            if (clr_addr_reg == PAGE_W'(PAGE_COUNT - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_page];
        end
    end

    assign ready       = !clr_active_reg;
    assign rd_resident = rd_data_reg[FRAME_W];
    assign rd_frame    = rd_data_reg[FRAME_W-1:0];

endmodule

>>> sv/tlb_page_translation_core.sv
// ----------------------------------------------------------------------------
// tlb_page_translation_core
// Virtual to physical address translation with a small fully associative
// tlb, fifo refill and demand paging through an on-chip page table.
//
//  channel   dir  signals                      contents
//  s_axis    in   tvalid tready tdata[15:0]    virtual address
//  m_axis    out  tvalid tready tdata[111:0]   phys addr, access/tlb/table counts
//                 tuser[1:0]                   tlb hit, page fault
//
//  each transfer: tlb compare and page table read on accept, then resolve,
//  write back and load the output register in the lookup state, as the
//  page table read is registered; after reset the page table is swept
//  clear and no input is taken until the sweep ends
//  a result waits in the output register; a stalled output holds the next
//  item in the lookup state until the register frees up
// ----------------------------------------------------------------------------
module tlb_page_translation_core
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] virtual_address
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [15:0] physical_address,
                                                   // [47:16] access_count,
                                                   // [79:48] tlb_hit_count,
                                                   // [111:80] table_hit_count
    output logic [OUT_TUSER_W-1:0] m_axis_tuser    // [0] tlb_hit, [1] page_fault
);

    localparam int PAGE_W  = $clog2(PAGE_COUNT);
    localparam int FRAME_W = $clog2(PAGE_COUNT);
    localparam int NF_W    = $clog2(PAGE_COUNT + 1);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    state_t state_reg;
    state_t state_next;

    logic                   accept;
    logic                   lookup_done;
    logic                   pt_ready;
    logic [VA_W-1:0]        vpn;
    logic [PAGE_W-1:0]      in_page;

    logic [PAGE_W-1:0]      page_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic                   hit_reg;
    logic [FRAME_W-1:0]     hit_frame_reg;

    logic                   tlb_hit;
    logic [FRAME_W-1:0]     tlb_hit_frame;
    logic                   pt_resident;
    logic [FRAME_W-1:0]     pt_frame;

    logic                   fault;
    logic                   table_hit;
    logic [FRAME_W-1:0]     frame;
    logic [31:0]            phys_wide;

    logic [NF_W-1:0]        next_free_reg;
    logic [CNT_W-1:0]       access_cnt_reg;
    logic [CNT_W-1:0]       access_cnt_next;
    logic [CNT_W-1:0]       tlb_hit_cnt_reg;
    logic [CNT_W-1:0]       tlb_hit_cnt_next;
    logic [CNT_W-1:0]       table_hit_cnt_reg;
    logic [CNT_W-1:0]       table_hit_cnt_next;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TUSER_W-1:0] out_user_reg;

    // ---------------- address split ----------------
    assign vpn     = s_axis_tdata >> OFFSET_BITS;
    assign in_page = vpn[PAGE_W-1:0];

    // ---------------- control ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (lookup_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        lookup_done   = 1'b0;
        case (state_reg)
            ST_IDLE:   s_axis_tready = pt_ready;
            ST_LOOKUP: lookup_done   = !out_valid_reg || m_axis_tready;
            default:
            begin
                s_axis_tready = 1'b0;
                lookup_done   = 1'b0;
            end
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // tlb compare and page table read on accept
    tlbpt_tlb #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PAGE_W      (PAGE_W),
        .FRAME_W     (FRAME_W)
    ) u_tlb (
        .clk         (clk),
        .rst_n       (rst_n),
        .lookup_page (in_page),
        .hit         (tlb_hit),
        .hit_frame   (tlb_hit_frame),
        .fill_en     (lookup_done && !hit_reg),
        .fill_page   (page_reg),
        .fill_frame  (frame)
    );

    tlbpt_page_table #(
        .PAGE_COUNT  (PAGE_COUNT),
        .FRAME_W     (FRAME_W)
    ) u_page_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .ready       (pt_ready),
        .rd_en       (accept),
        .rd_page     (in_page),
        .rd_resident (pt_resident),
        .rd_frame    (pt_frame),
        .wr_en       (lookup_done && fault),
        .wr_page     (page_reg),
        .wr_frame    (next_free_reg[FRAME_W-1:0])
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg      <= in_page;
            offset_reg    <= s_axis_tdata[OFFSET_BITS-1:0];
            hit_reg       <= tlb_hit;
            hit_frame_reg <= tlb_hit_frame;
        end
    end

    // resolve and write back in the lookup state
    always_comb
    begin
        fault     = !hit_reg && !pt_resident;
        table_hit = !hit_reg && pt_resident;
        if (hit_reg)
        begin
            frame = hit_frame_reg;
        end
        else if (pt_resident)
        begin
            frame = pt_frame;
        end
        else
        begin
            frame = next_free_reg[FRAME_W-1:0];
        end
        phys_wide = (32'(frame) << OFFSET_BITS) | 32'(offset_reg);

        access_cnt_next    = sat_inc(access_cnt_reg);
        tlb_hit_cnt_next   = hit_reg ? sat_inc(tlb_hit_cnt_reg) : tlb_hit_cnt_reg;
        table_hit_cnt_next = table_hit ? sat_inc(table_hit_cnt_reg) : table_hit_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_reg     <= '0;
            access_cnt_reg    <= '0;
            tlb_hit_cnt_reg   <= '0;
            table_hit_cnt_reg <= '0;
        end
        else if (lookup_done)
        begin
            access_cnt_reg    <= access_cnt_next;
            tlb_hit_cnt_reg   <= tlb_hit_cnt_next;
            table_hit_cnt_reg <= table_hit_cnt_next;
            if (fault && (next_free_reg != NF_W'(PAGE_COUNT)))
            begin
                next_free_reg <= next_free_reg + NF_W'(1);
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (lookup_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lookup_done)
        begin
            out_data_reg <= {table_hit_cnt_next, tlb_hit_cnt_next, access_cnt_next,
                             phys_wide[PA_W-1:0]};
            out_user_reg[TUSER_HIT]   <= hit_reg;
            out_user_reg[TUSER_FAULT] <= fault;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

`ifndef SYNTHESIS
    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[TUSER_HIT] && m_axis_tuser[TUSER_FAULT]))
        else $error("result flags both tlb hit and page fault");

    a_no_take_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        !pt_ready |-> !s_axis_tready)
        else $error("input taken while page table sweep runs");

    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_LOOKUP))
        else $error("accepted transfer did not enter lookup");

    a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        lookup_done |=> (m_axis_tvalid && (state_reg == ST_IDLE)))
        else $error("finished lookup did not present a result");
`endif

endmodule
